// ===== hw/rtl/dtba_pkg.sv =====
// Shared types and constants for the dynamic threshold buffer admission block.
// Holds the operation codes, register map, reset values and the structs
// passed between the front end, the back end and the queues. No dependencies.
package dtba_pkg;

  localparam int DEF_PORTS  = 32;
  localparam int DEF_QUEUES = 8;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] FUNC_IN_CHECK   = 3'd0;
  localparam logic [2:0] FUNC_IN_ADD     = 3'd1;
  localparam logic [2:0] FUNC_IN_REMOVE  = 3'd2;
  localparam logic [2:0] FUNC_OUT_CHECK  = 3'd3;
  localparam logic [2:0] FUNC_OUT_ADD    = 3'd4;
  localparam logic [2:0] FUNC_OUT_REMOVE = 3'd5;

  localparam logic [2:0] REG_BUFFER_POOL  = 3'd0;
  localparam logic [2:0] REG_INGRESS_POOL = 3'd1;
  localparam logic [2:0] REG_EGRESS_POOL  = 3'd2;
  localparam logic [2:0] REG_ALPHA_IN     = 3'd3;
  localparam logic [2:0] REG_ALPHA_OUT    = 3'd4;

  localparam logic [31:0] RST_BUFFER_POOL  = 32'd25165824;
  localparam logic [31:0] RST_INGRESS_POOL = 32'd18874368;
  localparam logic [31:0] RST_EGRESS_POOL  = 32'd25165824;
  localparam logic [23:0] RST_ALPHA        = 24'd256;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_ADD,
    OP_REMOVE
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        egress;
    op_t         op;
    logic        func_ok;
    logic        index_ok;
    logic [4:0]  port;
    logic [2:0]  queue;
    logic [15:0] psize;
  } cmd_t;

  typedef struct packed {
    logic        admitted;
    logic [47:0] thr;
    logic [31:0] qbytes;
    logic [31:0] used;
  } res_t;

  typedef struct packed {
    logic [31:0] buffer_pool;
    logic [31:0] ingress_pool;
    logic [31:0] egress_pool;
    logic [23:0] alpha_in;
    logic [23:0] alpha_out;
  } cfg_t;

endpackage

// ===== hw/rtl/dtba_fifo.sv =====
// Two-entry register queue used between the front and back ends and at the output.
// Standalone; the payload width is set by the instantiating module.
module dtba_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/dtba_front.sv =====
// Front end: accepts packet events, decodes the operation and range-checks the
// indexes, then queues the decoded command. Uses dtba_pkg and dtba_fifo.
module dtba_front #(
  parameter int PORTS  = dtba_pkg::DEF_PORTS,
  parameter int QUEUES = dtba_pkg::DEF_QUEUES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    func,
  input  logic [4:0]    port_index,
  input  logic [2:0]    queue_index,
  input  logic [15:0]   packet_bytes,
  input  logic          clearing,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output dtba_pkg::cmd_t cmd
);
  import dtba_pkg::*;

  cmd_t dec;
  logic fifo_full;

  always_comb begin
    dec          = '0;
    dec.port     = port_index;
    dec.queue    = queue_index;
    dec.psize    = packet_bytes;
    dec.index_ok = ({4'b0, port_index} < 9'(PORTS)) && ({2'b0, queue_index} < 5'(QUEUES));
    unique case (func)
      FUNC_IN_CHECK: begin
        dec.egress = 1'b0; dec.op = OP_CHECK;  dec.func_ok = 1'b1;
      end
      FUNC_IN_ADD: begin
        dec.egress = 1'b0; dec.op = OP_ADD;    dec.func_ok = 1'b1;
      end
      FUNC_IN_REMOVE: begin
        dec.egress = 1'b0; dec.op = OP_REMOVE; dec.func_ok = 1'b1;
      end
      FUNC_OUT_CHECK: begin
        dec.egress = 1'b1; dec.op = OP_CHECK;  dec.func_ok = 1'b1;
      end
      FUNC_OUT_ADD: begin
        dec.egress = 1'b1; dec.op = OP_ADD;    dec.func_ok = 1'b1;
      end
      FUNC_OUT_REMOVE: begin
        dec.egress = 1'b1; dec.op = OP_REMOVE; dec.func_ok = 1'b1;
      end
      default: begin
        dec.egress = 1'b0; dec.op = OP_CHECK;  dec.func_ok = 1'b0;
      end
    endcase
  end

  assign full = fifo_full || clearing;

  dtba_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !clearing),
    .wdata (dec),
    .full  (fifo_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// ===== hw/rtl/dtba_back.sv =====
// Back end: per-queue counter memory, used counters and threshold arithmetic.
// Clears the memory after reset, then sequences load, update and result steps per command. Uses dtba_pkg.
module dtba_back #(
  parameter int PORTS  = dtba_pkg::DEF_PORTS,
  parameter int QUEUES = dtba_pkg::DEF_QUEUES
) (
  input  logic           clk,
  input  logic           rst,
  input  dtba_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  input  dtba_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output dtba_pkg::res_t res,
  output logic           clearing
);
  import dtba_pkg::*;

  localparam int DEPTH = PORTS * QUEUES;
  localparam int AW    = $clog2(2 * DEPTH);

  state_t      state;
  state_t      state_next;

  logic [31:0] mem [2 * DEPTH];
  logic [31:0] mem_rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] addr;
  logic [AW-1:0] clear_cnt;
  logic        clear_last;

  logic [31:0] total_used;
  logic [31:0] egress_used;

  cmd_t        cur;
  logic        active;
  logic [31:0] used_sel;
  logic [31:0] pool_sel;
  logic [32:0] used_sum;
  logic [31:0] used_new;
  logic        ok_pool;
  logic        ok_buf;
  logic [31:0] used_r;
  logic [31:0] remain;
  logic        pool_full;
  logic [23:0] alpha;
  logic [55:0] product;
  logic [47:0] thr;
  logic [32:0] qc_sum;
  logic [31:0] qc_new;
  logic [31:0] qbytes;
  logic [48:0] q_total;
  logic        ok_queue;

  assign active = cmd.func_ok && cmd.index_ok;
  assign used_sel = cmd.egress ? egress_used : total_used;
  assign pool_sel = cmd.egress ? cfg.egress_pool : cfg.ingress_pool;
  assign used_sum = {1'b0, used_sel} + {17'b0, cmd.psize};
  assign load_addr = AW'(AW'(cmd.port) * AW'(QUEUES)) + AW'(cmd.queue)
                   + (cmd.egress ? AW'(DEPTH) : '0);
  assign clear_last = (clear_cnt == AW'(2 * DEPTH - 1));

  always_comb begin
    used_new = used_sel;
    if (active) begin
      case (cmd.op)
        OP_ADD:    used_new = used_sum[32] ? CNT_MAX : used_sum[31:0];
        OP_REMOVE: used_new = (used_sel >= {16'b0, cmd.psize}) ?
                              used_sel - {16'b0, cmd.psize} : 32'd0;
        default:   used_new = used_sel;
      endcase
    end
  end

  always_comb begin
    qc_sum = {1'b0, mem_rdata} + {17'b0, cur.psize};
    case (cur.op)
      OP_ADD:    qc_new = qc_sum[32] ? CNT_MAX : qc_sum[31:0];
      OP_REMOVE: qc_new = (mem_rdata >= {16'b0, cur.psize}) ?
                          mem_rdata - {16'b0, cur.psize} : 32'd0;
      default:   qc_new = mem_rdata;
    endcase
  end

  assign product  = 56'(alpha) * 56'(remain);
  assign q_total  = {17'b0, qbytes} + {33'b0, cur.psize};
  assign ok_queue = (q_total <= {1'b0, thr});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clear_last) state_next = ST_LOAD;
      ST_LOAD:   if (!cmd_empty) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE:   if (!res_full) state_next = ST_LOAD;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_pop  = (state == ST_LOAD) && !cmd_empty;
    res_push = (state == ST_DONE) && !res_full;
    clearing = (state == ST_CLEAR);
    mem_we   = clearing || ((state == ST_UPDATE) && cur.func_ok && cur.index_ok
                            && (cur.op != OP_CHECK));
    mem_waddr = clearing ? clear_cnt : addr;
    mem_wdata = clearing ? 32'd0 : qc_new;
  end

  always_comb begin
    res = '0;
    if (cur.func_ok) begin
      res.admitted = cur.index_ok && (cur.op == OP_CHECK) && ok_queue && ok_pool && ok_buf;
      res.thr      = thr;
      res.qbytes   = qbytes;
      res.used     = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_cnt   <= '0;
      total_used  <= 32'd0;
      egress_used <= 32'd0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_cnt <= clear_cnt + AW'(1);
      end
      if (cmd_pop && active) begin
        if (cmd.egress) begin
          egress_used <= used_new;
        end else begin
          total_used <= used_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur       <= cmd;
      addr      <= load_addr;
      used_r    <= used_new;
      ok_pool   <= (used_sum <= {1'b0, pool_sel});
      ok_buf    <= (({1'b0, total_used} + {17'b0, cmd.psize}) <= {1'b0, cfg.buffer_pool});
      pool_full <= (pool_sel <= used_new);
      remain    <= pool_sel - used_new;
      alpha     <= cmd.egress ? cfg.alpha_out : cfg.alpha_in;
    end
    if (state == ST_UPDATE) begin
      thr    <= pool_full ? 48'd0 : product[55:8];
      qbytes <= cur.index_ok ? qc_new : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[load_addr];
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !res_push)
    else $error("result produced during the clearing pass");

  a_update_follows_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> $past(state) == ST_LOAD)
    else $error("update step not preceded by a load");

  a_admit_only_on_check: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.admitted) |-> (cur.op == OP_CHECK && cur.func_ok && cur.index_ok))
    else $error("admission flagged for a non-check operation");

  a_check_keeps_used: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.op == OP_CHECK) |=> ($stable(total_used) && $stable(egress_used)))
    else $error("check operation changed a used counter");

endmodule

// ===== hw/rtl/dynamic_threshold_buffer_admission.sv =====
// Top level of the dynamic threshold buffer admission block.
// Holds the configuration registers and the result queue; uses dtba_pkg,
// dtba_front, dtba_back and dtba_fifo.
//
// Packet events enter through a queue-style port: an event is taken when
// push is high and full is low. Each event is an ingress or egress check,
// add or remove for one port and queue. Every event produces exactly one
// result, offered while empty is low and taken when pop is high.
// Each event taken passes from the command queue through the back end's
// load state, which reads the queue counter memory, its update state,
// which writes it back while the threshold multiplier runs, and its
// result state, which compares and queues the result, waiting while the
// result queue is full; the next event is loaded only after that.
// Two-entry queues sit on both sides of the back end, so a stalled
// receiver holds results there and input keeps being taken until they fill.
// After reset, the counter memory is cleared one entry per cycle, all
// 2*PORTS*QUEUES entries (512 with the default sizes); full stays high
// during that time. Configuration registers are written through the APB
// port, at byte address 4*i, and should be changed only while idle.
module dynamic_threshold_buffer_admission #(
  parameter int PORTS  = dtba_pkg::DEF_PORTS,
  parameter int QUEUES = dtba_pkg::DEF_QUEUES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func,
  input  logic [4:0]  port_index,
  input  logic [2:0]  queue_index,
  input  logic [15:0] packet_bytes,
  output logic        empty,
  input  logic        pop,
  output logic        admitted,
  output logic [47:0] threshold_bytes,
  output logic [31:0] queue_bytes,
  output logic [31:0] pool_used_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtba_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  logic        cmd_empty;
  logic        cmd_pop;
  logic        clearing;
  logic        res_full;
  logic        res_push;
  res_t        res_in;
  res_t        res_out;
  logic [2:0]  reg_index;
  logic        reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_pool  <= RST_BUFFER_POOL;
      cfg.ingress_pool <= RST_INGRESS_POOL;
      cfg.egress_pool  <= RST_EGRESS_POOL;
      cfg.alpha_in     <= RST_ALPHA;
      cfg.alpha_out    <= RST_ALPHA;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_BUFFER_POOL:  cfg.buffer_pool  <= pwdata;
        REG_INGRESS_POOL: cfg.ingress_pool <= pwdata;
        REG_EGRESS_POOL:  cfg.egress_pool  <= pwdata;
        REG_ALPHA_IN:     cfg.alpha_in     <= pwdata[23:0];
        REG_ALPHA_OUT:    cfg.alpha_out    <= pwdata[23:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_BUFFER_POOL:  prdata = cfg.buffer_pool;
      REG_INGRESS_POOL: prdata = cfg.ingress_pool;
      REG_EGRESS_POOL:  prdata = cfg.egress_pool;
      REG_ALPHA_IN:     prdata = {8'b0, cfg.alpha_in};
      REG_ALPHA_OUT:    prdata = {8'b0, cfg.alpha_out};
      default:          prdata = 32'd0;
    endcase
  end

  dtba_front #(
    .PORTS  (PORTS),
    .QUEUES (QUEUES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .port_index   (port_index),
    .queue_index  (queue_index),
    .packet_bytes (packet_bytes),
    .clearing     (clearing),
    .cmd_pop      (cmd_pop),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd)
  );

  dtba_back #(
    .PORTS  (PORTS),
    .QUEUES (QUEUES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  dtba_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign admitted        = res_out.admitted;
  assign threshold_bytes = res_out.thr;
  assign queue_bytes     = res_out.qbytes;
  assign pool_used_bytes = res_out.used;

endmodule
